/* rtl/core/paqi_pkg.sv */
// Shared types and constants for the particulate air quality index core.
// Holds the breakpoint tables with their reciprocal constants and the lane structs.
// No dependencies.
package paqi_pkg;

   localparam int SEGMENT_COUNT  = 7;
   localparam int TABLE_SEGMENTS = 7;
   localparam int SEARCH_SEGMENTS =
      (SEGMENT_COUNT < TABLE_SEGMENTS) ? SEGMENT_COUNT : TABLE_SEGMENTS;

   localparam int CONC_W    = 16;
   localparam int INDEX_W   = 13;
   localparam int OFFSET_W  = 11;
   localparam int QUOT_W    = 10;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W   = 27;
   localparam int PROD_W    = OFFSET_W + RECIP_W;

   typedef struct packed {
      logic [CONC_W-1:0]  lo;
      logic [CONC_W-1:0]  hi;
      logic [RECIP_W-1:0] recip;
      logic [INDEX_W-1:0] base;
   } seg_entry_type;

   typedef seg_entry_type seg_table_type [TABLE_SEGMENTS];

   typedef struct packed {
      logic s1_en;
      logic s2_en;
   } lane_ctl_type;

   typedef struct packed {
      logic               hit;
      logic [INDEX_W-1:0] base;
      logic [QUOT_W-1:0]  quot;
   } lane_result_type;

   // recip = ceil(10 * anchor span * 2^RECIP_SHIFT / (hi - lo)); exact since 2^24 > span^2
   localparam seg_table_type FINE_TABLE = '{
      '{lo: 16'd0,    hi: 16'd120,
        recip: RECIP_W'(((64'd500 << RECIP_SHIFT) + 64'd119) / 64'd120),   base: 13'd0},
      '{lo: 16'd121,  hi: 16'd354,
        recip: RECIP_W'(((64'd500 << RECIP_SHIFT) + 64'd232) / 64'd233),   base: 13'd500},
      '{lo: 16'd355,  hi: 16'd554,
        recip: RECIP_W'(((64'd500 << RECIP_SHIFT) + 64'd198) / 64'd199),   base: 13'd1000},
      '{lo: 16'd555,  hi: 16'd1504,
        recip: RECIP_W'(((64'd500 << RECIP_SHIFT) + 64'd948) / 64'd949),   base: 13'd1500},
      '{lo: 16'd1505, hi: 16'd2504,
        recip: RECIP_W'(((64'd1000 << RECIP_SHIFT) + 64'd998) / 64'd999),  base: 13'd2000},
      '{lo: 16'd2505, hi: 16'd3504,
        recip: RECIP_W'(((64'd1000 << RECIP_SHIFT) + 64'd998) / 64'd999),  base: 13'd3000},
      '{lo: 16'd3505, hi: 16'd5004,
        recip: RECIP_W'(((64'd1000 << RECIP_SHIFT) + 64'd1498) / 64'd1499), base: 13'd4000}
   };

   localparam seg_table_type COARSE_TABLE = '{
      '{lo: 16'd0,    hi: 16'd540,
        recip: RECIP_W'(((64'd500 << RECIP_SHIFT) + 64'd539) / 64'd540),   base: 13'd0},
      '{lo: 16'd550,  hi: 16'd1540,
        recip: RECIP_W'(((64'd500 << RECIP_SHIFT) + 64'd989) / 64'd990),   base: 13'd500},
      '{lo: 16'd1550, hi: 16'd2540,
        recip: RECIP_W'(((64'd500 << RECIP_SHIFT) + 64'd989) / 64'd990),   base: 13'd1000},
      '{lo: 16'd2550, hi: 16'd3540,
        recip: RECIP_W'(((64'd500 << RECIP_SHIFT) + 64'd989) / 64'd990),   base: 13'd1500},
      '{lo: 16'd3550, hi: 16'd4240,
        recip: RECIP_W'(((64'd1000 << RECIP_SHIFT) + 64'd689) / 64'd690),  base: 13'd2000},
      '{lo: 16'd4250, hi: 16'd5040,
        recip: RECIP_W'(((64'd1000 << RECIP_SHIFT) + 64'd789) / 64'd790),  base: 13'd3000},
      '{lo: 16'd5050, hi: 16'd6040,
        recip: RECIP_W'(((64'd1000 << RECIP_SHIFT) + 64'd989) / 64'd990),  base: 13'd4000}
   };

endpackage

/* rtl/core/particulate_air_quality_index_core.sv */
// Particulate air quality index core: two pollutant lanes and a max merge stage.
// rsp_tvalid rises once an accepted item has passed the search, multiply and merge registers.
// Throughput: one item per cycle; a stage holds its item only while the next is full and stalled.
// Reset (synchronous, active high) clears the stage valid bits; no tables need loading.
// Depends on paqi_pkg, paqi_lane and paqi_merge.
module particulate_air_quality_index_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] pm25_tenths, [31:16] pm10_tenths
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [12:0] index_tenths, [15:13] zero
   output logic [1:0]  rsp_tuser    // [0] fine_in_range, [1] coarse_in_range
);

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic adv1, adv2, adv3;
   paqi_pkg::lane_ctl_type    ctl;
   paqi_pkg::lane_result_type fine_res, coarse_res;
   logic [paqi_pkg::INDEX_W-1:0] index_tenths;
   logic fine_in_range, coarse_in_range;

   assign adv3 = !v3_ff || rsp_tready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign v1_in = adv1 ? req_tvalid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign ctl.s1_en = adv1;
   assign ctl.s2_en = adv2;

   paqi_lane u_fine_lane (
      .clock     (clock),
      .conc      (req_tdata[15:0]),
      .seg_table (paqi_pkg::FINE_TABLE),
      .ctl       (ctl),
      .result    (fine_res)
   );

   paqi_lane u_coarse_lane (
      .clock     (clock),
      .conc      (req_tdata[31:16]),
      .seg_table (paqi_pkg::COARSE_TABLE),
      .ctl       (ctl),
      .result    (coarse_res)
   );

   paqi_merge u_merge (
      .clock           (clock),
      .load            (adv3),
      .fine            (fine_res),
      .coarse          (coarse_res),
      .index_tenths    (index_tenths),
      .fine_in_range   (fine_in_range),
      .coarse_in_range (coarse_in_range)
   );

   assign req_tready = adv1;
   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {3'b000, index_tenths};
   assign rsp_tuser  = {coarse_in_range, fine_in_range};

   a_index_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[12:0] != 13'd0) |-> (rsp_tuser != 2'b00))
      else $error("nonzero index without any segment hit");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[12:0] <= 13'd5000))
      else $error("index above 500.0");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v1_ff)
      else $error("accepted item lost at first stage");

   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !adv2 |=> v2_ff && $stable(fine_res) && $stable(coarse_res))
      else $error("stalled multiply stage changed");

   a_s1_to_s2: assert property (@(posedge clock) disable iff (reset)
      v1_ff && adv2 |=> v2_ff)
      else $error("item dropped between stages");

endmodule

/* rtl/core/paqi_lane.sv */
// One pollutant lane: segment search, offset and reciprocal select, then scaling multiply.
// Two register stages, enabled from the top-level pipeline control.
// Depends on paqi_pkg.
module paqi_lane (
   input  logic                           clock,
   input  logic [paqi_pkg::CONC_W-1:0]    conc,
   input  paqi_pkg::seg_table_type        seg_table,
   input  paqi_pkg::lane_ctl_type         ctl,
   output paqi_pkg::lane_result_type      result
);

   logic                             hit_in, hit_ff, hit2_ff;
   logic [paqi_pkg::OFFSET_W-1:0]    offset_in, offset_ff;
   logic [paqi_pkg::RECIP_W-1:0]     recip_in, recip_ff;
   logic [paqi_pkg::INDEX_W-1:0]     base_in, base_ff, base2_ff;
   logic [paqi_pkg::CONC_W-1:0]      diff;
   logic [paqi_pkg::PROD_W-1:0]      prod;
   logic [paqi_pkg::QUOT_W-1:0]      quot_in, quot_ff;

   // first matching segment wins: scan from the top so lower ones override
   always_comb begin
      hit_in    = 1'b0;
      offset_in = '0;
      recip_in  = '0;
      base_in   = '0;
      diff      = '0;
      for (int i = paqi_pkg::SEARCH_SEGMENTS - 1; i >= 0; i--) begin
         if (conc >= seg_table[i].lo && conc <= seg_table[i].hi) begin
            hit_in    = 1'b1;
            diff      = conc - seg_table[i].lo;
            offset_in = diff[paqi_pkg::OFFSET_W-1:0];
            recip_in  = seg_table[i].recip;
            base_in   = seg_table[i].base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         hit_ff    <= hit_in;
         offset_ff <= offset_in;
         recip_ff  <= recip_in;
         base_ff   <= base_in;
      end
   end

   assign prod    = paqi_pkg::PROD_W'(offset_ff) * paqi_pkg::PROD_W'(recip_ff);
   assign quot_in = prod[paqi_pkg::RECIP_SHIFT +: paqi_pkg::QUOT_W];

   always_ff @(posedge clock) begin
      if (ctl.s2_en) begin
         hit2_ff  <= hit_ff;
         base2_ff <= base_ff;
         quot_ff  <= quot_in;
      end
   end

   assign result.hit  = hit2_ff;
   assign result.base = base2_ff;
   assign result.quot = quot_ff;

endmodule

/* rtl/core/paqi_merge.sv */
// Merge stage: completes both lane indices, takes the larger and registers the result.
// Depends on paqi_pkg.
module paqi_merge (
   input  logic                            clock,
   input  logic                            load,
   input  paqi_pkg::lane_result_type       fine,
   input  paqi_pkg::lane_result_type       coarse,
   output logic [paqi_pkg::INDEX_W-1:0]    index_tenths,
   output logic                            fine_in_range,
   output logic                            coarse_in_range
);

   logic [paqi_pkg::INDEX_W-1:0] fine_idx, coarse_idx;
   logic [paqi_pkg::INDEX_W-1:0] index_in, index_ff;
   logic                         fine_ff, coarse_ff;

   assign fine_idx   = fine.base + paqi_pkg::INDEX_W'(fine.quot);
   assign coarse_idx = coarse.base + paqi_pkg::INDEX_W'(coarse.quot);
   assign index_in   = (fine_idx > coarse_idx) ? fine_idx : coarse_idx;

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff  <= index_in;
         fine_ff   <= fine.hit;
         coarse_ff <= coarse.hit;
      end
   end

   assign index_tenths    = index_ff;
   assign fine_in_range   = fine_ff;
   assign coarse_in_range = coarse_ff;

endmodule

/* sim/particulate_air_quality_index_core_tb.sv */
// Testbench for particulate_air_quality_index_core: streams PM2.5/PM10 pairs, predicts the
// index and both in-range flags per item and checks every response in order.
// Depends on paqi_pkg and the core RTL.
module particulate_air_quality_index_core_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 420;
   localparam int REPORT_LIMIT = 10;

   class air_index_scoreboard;
      typedef struct packed {
         logic [15:0] data;
         logic [1:0]  flags;
      } reading_type;

      int unsigned anchor [8]    = '{0, 50, 100, 150, 200, 300, 400, 500};
      int unsigned fine_lo [7]   = '{0, 121, 355, 555, 1505, 2505, 3505};
      int unsigned fine_hi [7]   = '{120, 354, 554, 1504, 2504, 3504, 5004};
      int unsigned coarse_lo [7] = '{0, 550, 1550, 2550, 3550, 4250, 5050};
      int unsigned coarse_hi [7] = '{540, 1540, 2540, 3540, 4240, 5040, 6040};

      reading_type expected_readings [$];
      int          failures;

      function int unsigned segment_tenths(int unsigned conc, bit coarse, output bit hit);
         int unsigned lo;
         int unsigned hi;
         int          segs;
         segs = (paqi_pkg::SEGMENT_COUNT < 7) ? paqi_pkg::SEGMENT_COUNT : 7;
         hit = 1'b0;
         for (int i = 0; i < segs; i++) begin
            lo = coarse ? coarse_lo[i] : fine_lo[i];
            hi = coarse ? coarse_hi[i] : fine_hi[i];
            if (conc >= lo && conc <= hi) begin
               hit = 1'b1;
               return anchor[i] * 10 + ((conc - lo) * 10 * (anchor[i+1] - anchor[i])) / (hi - lo);
            end
         end
         return 0;
      endfunction

      function void note_sample(logic [31:0] sample);
         reading_type r;
         bit          fine_hit;
         bit          coarse_hit;
         int unsigned fine_idx;
         int unsigned coarse_idx;
         fine_idx   = segment_tenths(sample[15:0], 1'b0, fine_hit);
         coarse_idx = segment_tenths(sample[31:16], 1'b1, coarse_hit);
         r.data  = {3'b000, 13'((fine_idx > coarse_idx) ? fine_idx : coarse_idx)};
         r.flags = {coarse_hit, fine_hit};
         expected_readings.push_back(r);
      endfunction

      function void check_reading(logic [15:0] data, logic [1:0] flags);
         reading_type r;
         if (expected_readings.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected response: index %0d flags %b", data, flags);
            return;
         end
         r = expected_readings.pop_front();
         if (data !== r.data || flags !== r.flags) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("mismatch: expected index %0d flags %b, got index %0d flags %b",
                        r.data, r.flags, data, flags);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] pm25_tenths, [31:16] pm10_tenths
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [12:0] index_tenths, [15:13] zero
   logic [1:0]  rsp_tuser;        // [0] fine_in_range, [1] coarse_in_range

   air_index_scoreboard sb = new();
   int unsigned send_idle  = 0;
   int unsigned recv_stall = 0;
   int unsigned cycles     = 0;

   particulate_air_quality_index_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_reading(rsp_tdata, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("particulate_air_quality_index_core_tb failed");
         $finish;
      end
   end

   task automatic send_item(input logic [15:0] pm25, input logic [15:0] pm10);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pm10, pm25};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // mostly in-table values, some hugging segment edges, a few anywhere in 16 bits
   function automatic logic [15:0] pick_conc(bit coarse);
      int unsigned edge_val;
      int          k;
      case ($urandom_range(9))
         0: return 16'($urandom);
         1, 2: begin
            k = $urandom_range(6);
            if ($urandom_range(1))
               edge_val = coarse ? sb.coarse_hi[k] : sb.fine_hi[k];
            else
               edge_val = coarse ? sb.coarse_lo[k] : sb.fine_lo[k];
            return 16'(edge_val + 3 - $urandom_range(6));
         end
         default: return 16'($urandom_range(coarse ? 6200 : 5200));
      endcase
   endfunction

   task automatic run_phase(input int unsigned idle, input int unsigned stall);
      send_idle  = idle;
      recv_stall = stall;
      repeat (PHASE_ITEMS)
         send_item(pick_conc(1'b0), pick_conc(1'b1));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // segment edges, coarse gaps, above-table values and both-out-of-range
      send_item(16'd0,     16'd0);
      send_item(16'd65535, 16'd65535);
      send_item(16'd120,   16'd540);
      send_item(16'd121,   16'd541);
      send_item(16'd354,   16'd549);
      send_item(16'd355,   16'd550);
      send_item(16'd554,   16'd1540);
      send_item(16'd555,   16'd1549);
      send_item(16'd1504,  16'd1550);
      send_item(16'd1505,  16'd2540);
      send_item(16'd2504,  16'd2550);
      send_item(16'd2505,  16'd3540);
      send_item(16'd3504,  16'd3550);
      send_item(16'd3505,  16'd4240);
      send_item(16'd5004,  16'd4249);
      send_item(16'd5005,  16'd4250);
      send_item(16'd0,     16'd5040);
      send_item(16'd65535, 16'd5049);
      send_item(16'd100,   16'd5050);
      send_item(16'd5005,  16'd6040);
      send_item(16'd200,   16'd6041);
      send_item(16'd32768, 16'd0);
      send_item(16'd0,     16'd32768);
      send_item(16'd5004,  16'd6040);
      send_item(16'd60,    16'd270);

      run_phase(0, 0);
      run_phase(64, 0);
      run_phase(0, 64);
      run_phase(35, 35);
      req_tvalid <= 1'b0;

      while (sb.expected_readings.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (sb.failures == 0 && sb.expected_readings.size() == 0)
         $display("particulate_air_quality_index_core_tb passed");
      else
         $display("particulate_air_quality_index_core_tb failed");
      $finish;
   end

endmodule
